// ----- rtl/core/stag_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite texel address generator package
// Shared types, constants and size-table functions for the texel address path.
// ----------------------------------------------------------------------------
`default_nettype none

package stag_pkg;

  localparam int SCREEN_WIDTH = 240;

  // Configuration register indexes.
  localparam logic REG_ONE_DIM     = 1'b0;
  localparam logic REG_BITMAP_BASE = 1'b1;

  // Object mode codes.
  localparam logic [1:0] MODE_AFFINE = 2'd1;
  localparam logic [1:0] MODE_HIDDEN = 2'd2;
  localparam logic [1:0] MODE_DOUBLE = 2'd3;

  localparam logic [1:0] SHAPE_PROHIBITED = 2'd3;

  localparam logic [16:0] TILE_BASE_OBJ    = 17'h10000;
  localparam logic [16:0] TILE_BASE_BITMAP = 17'h14000;

  typedef struct packed {
    logic [15:0]        attr_word0;
    logic [15:0]        attr_word1;
    logic [15:0]        attr_word2;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
    logic signed [15:0] coef_d;
    logic [7:0]         line_number;
    logic [6:0]         column_in_sprite;
  } stag_in_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  screen_x;
    logic [16:0] vram_offset;
    logic        high_nibble;
    logic        eight_bpp;
    logic [3:0]  palette_bank;
    logic [1:0]  sprite_priority;
  } stag_out_t;

  typedef struct packed {
    logic one_dim;
    logic bitmap_base;
  } stag_cfg_t;

  // Decoded attributes and box position of one pixel.
  typedef struct packed {
    logic              shown;
    logic              affine;
    logic              is8;
    logic              hflip;
    logic              vflip;
    logic [1:0]        wk;
    logic [6:0]        w;
    logic [6:0]        h;
    logic [6:0]        px;
    logic [7:0]        ly;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [7:0]        screen_x;
    logic [9:0]        tile;
    logic [1:0]        prio;
    logic [3:0]        palette;
  } stag_attr_t;

  typedef struct packed {
    logic       in_tex;
    logic [5:0] tx;
    logic [5:0] ty;
  } stag_coord_t;

  // Texture width as 8 << result.
  function automatic logic [1:0] width_log2(input logic [1:0] shape, input logic [1:0] size);
    logic [1:0] k;
    case ({shape, size})
      4'b00_00: k = 2'd0;
      4'b00_01: k = 2'd1;
      4'b00_10: k = 2'd2;
      4'b00_11: k = 2'd3;
      4'b01_00: k = 2'd1;
      4'b01_01: k = 2'd2;
      4'b01_10: k = 2'd2;
      4'b01_11: k = 2'd3;
      4'b10_00: k = 2'd0;
      4'b10_01: k = 2'd0;
      4'b10_10: k = 2'd1;
      4'b10_11: k = 2'd2;
      default:  k = 2'd0;
    endcase
    return k;
  endfunction

  // Texture height as 8 << result.
  function automatic logic [1:0] height_log2(input logic [1:0] shape, input logic [1:0] size);
    logic [1:0] k;
    case ({shape, size})
      4'b00_00: k = 2'd0;
      4'b00_01: k = 2'd1;
      4'b00_10: k = 2'd2;
      4'b00_11: k = 2'd3;
      4'b01_00: k = 2'd0;
      4'b01_01: k = 2'd0;
      4'b01_10: k = 2'd1;
      4'b01_11: k = 2'd2;
      4'b10_00: k = 2'd1;
      4'b10_01: k = 2'd2;
      4'b10_10: k = 2'd2;
      4'b10_11: k = 2'd3;
      default:  k = 2'd0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stag_decode.sv -----
// ----------------------------------------------------------------------------
// Attribute decode
// Decodes mode, shape and size, and tests the pixel against the drawn box and
// the screen.
// ----------------------------------------------------------------------------
`default_nettype none

module stag_decode (
  input  wire stag_pkg::stag_in_t   item,
  output stag_pkg::stag_attr_t      attr
);

  logic [1:0]        mode;
  logic [1:0]        shape;
  logic [1:0]        size;
  logic              dbl;
  logic [1:0]        wk;
  logic [1:0]        hk;
  logic [6:0]        w;
  logic [6:0]        h;
  logic [7:0]        dw;
  logic [7:0]        dh;
  logic [6:0]        half_dw;
  logic [6:0]        half_dh;
  logic [7:0]        ly;
  logic [6:0]        px;
  logic [9:0]        sx;
  logic              row_ok;
  logic              col_ok;
  logic              scr_ok;
  logic              mode_ok;

  always_comb begin
    mode  = item.attr_word0[9:8];
    shape = item.attr_word0[15:14];
    size  = item.attr_word1[15:14];
    dbl   = (mode == stag_pkg::MODE_DOUBLE);
    wk    = stag_pkg::width_log2(shape, size);
    hk    = stag_pkg::height_log2(shape, size);
    w     = 7'd8 << wk;
    h     = 7'd8 << hk;
    dw    = dbl ? {w, 1'b0} : {1'b0, w};
    dh    = dbl ? {h, 1'b0} : {1'b0, h};
    half_dw = dbl ? w : (w >> 1);
    half_dh = dbl ? h : (h >> 1);

    // The row difference wraps round the 256-line frame.
    ly = item.line_number - item.attr_word0[7:0];
    px = item.column_in_sprite;

    // X is a 9-bit signed field.
    sx = {item.attr_word1[8], item.attr_word1[8:0]} + {3'b000, px};

    mode_ok = (mode != stag_pkg::MODE_HIDDEN) && (shape != stag_pkg::SHAPE_PROHIBITED);
    row_ok  = (ly < dh);
    col_ok  = ({1'b0, px} < dw);
    scr_ok  = !sx[9] && (sx < 10'(stag_pkg::SCREEN_WIDTH));

    attr.shown    = mode_ok && row_ok && col_ok && scr_ok;
    attr.affine   = (mode == stag_pkg::MODE_AFFINE) || (mode == stag_pkg::MODE_DOUBLE);
    attr.is8      = item.attr_word0[13];
    attr.hflip    = item.attr_word1[12];
    attr.vflip    = item.attr_word1[13];
    attr.wk       = wk;
    attr.w        = w;
    attr.h        = h;
    attr.px       = px;
    attr.ly       = ly;
    attr.dx       = $signed({2'b00, px}) - $signed({2'b00, half_dw});
    attr.dy       = $signed({1'b0, ly}) - $signed({2'b00, half_dh});
    attr.screen_x = sx[7:0];
    attr.tile     = item.attr_word2[9:0];
    attr.prio     = item.attr_word2[11:10];
    attr.palette  = item.attr_word2[15:12];
  end

endmodule

`default_nettype wire

// ----- rtl/core/stag_texel.sv -----
// ----------------------------------------------------------------------------
// Texel coordinate unit
// Works out the texture coordinates by the affine transform or by flipping.
// ----------------------------------------------------------------------------
`default_nettype none

module stag_texel (
  input  wire stag_pkg::stag_in_t   item,
  input  wire stag_pkg::stag_attr_t attr,
  output stag_pkg::stag_coord_t     coord
);

  logic signed [24:0] p_a;
  logic signed [24:0] p_b;
  logic signed [24:0] p_c;
  logic signed [24:0] p_d;
  logic signed [25:0] sum_x;
  logic signed [25:0] sum_y;
  logic signed [18:0] tx_full;
  logic signed [18:0] ty_full;
  logic               tx_in;
  logic               ty_in;
  logic [6:0]         w_m1;
  logic [6:0]         h_m1;
  logic [5:0]         tx_plain;
  logic [5:0]         ty_plain;

  always_comb begin
    p_a   = item.coef_a * attr.dx;
    p_b   = item.coef_b * attr.dy;
    p_c   = item.coef_c * attr.dx;
    p_d   = item.coef_d * attr.dy;
    sum_x = 26'(p_a) + 26'(p_b);
    sum_y = 26'(p_c) + 26'(p_d);

    // Taking the top bits of the 8.8 sum floors towards minus infinity.
    tx_full = $signed({sum_x[25], sum_x[25:8]}) + $signed({13'd0, attr.w[6:1]});
    ty_full = $signed({sum_y[25], sum_y[25:8]}) + $signed({13'd0, attr.h[6:1]});
    tx_in   = !tx_full[18] && (tx_full[17:0] < {11'd0, attr.w});
    ty_in   = !ty_full[18] && (ty_full[17:0] < {11'd0, attr.h});

    w_m1     = attr.w - 7'd1;
    h_m1     = attr.h - 7'd1;
    tx_plain = attr.hflip ? (w_m1[5:0] - attr.px[5:0]) : attr.px[5:0];
    ty_plain = attr.vflip ? (h_m1[5:0] - attr.ly[5:0]) : attr.ly[5:0];

    if (attr.affine) begin
      coord.in_tex = tx_in && ty_in;
      coord.tx     = tx_full[5:0];
      coord.ty     = ty_full[5:0];
    end else begin
      coord.in_tex = 1'b1;
      coord.tx     = tx_plain;
      coord.ty     = ty_plain;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stag_addr.sv -----
// ----------------------------------------------------------------------------
// Texel address unit
// Forms the video memory byte offset for 1D or 2D tile layout and builds the
// result word.
// ----------------------------------------------------------------------------
`default_nettype none

module stag_addr (
  input  wire stag_pkg::stag_cfg_t   cfg,
  input  wire stag_pkg::stag_attr_t  attr,
  input  wire stag_pkg::stag_coord_t coord,
  output stag_pkg::stag_out_t        result
);

  logic [2:0]  tx8;
  logic [2:0]  ty8;
  logic [6:0]  lin;
  logic [7:0]  step;
  logic [9:0]  tile_2d;
  logic [3:0]  col_2d;
  logic [11:0] tnum;
  logic [5:0]  byte_off;
  logic [16:0] base;
  logic [16:0] addr;
  logic        hit;

  always_comb begin
    tx8 = coord.tx[5:3];
    ty8 = coord.ty[5:3];

    // Tiles per texture row is a power of two, so the row step is a shift.
    lin  = ({4'd0, ty8} << attr.wk) + {4'd0, tx8};
    step = attr.is8 ? {lin, 1'b0} : {1'b0, lin};

    // In 2D layout an 8bpp tile spans two tile slots and bit 0 is dropped.
    tile_2d = attr.is8 ? {attr.tile[9:1], 1'b0} : attr.tile;
    col_2d  = attr.is8 ? {tx8, 1'b0} : {1'b0, tx8};

    if (cfg.one_dim) begin
      tnum = {2'b00, attr.tile} + {4'd0, step};
    end else begin
      tnum = {2'b00, tile_2d} + {4'd0, ty8, 5'd0} + {8'd0, col_2d};
    end

    byte_off = attr.is8 ? {coord.ty[2:0], coord.tx[2:0]}
                        : {1'b0, coord.ty[2:0], coord.tx[2:1]};
    base     = cfg.bitmap_base ? stag_pkg::TILE_BASE_BITMAP : stag_pkg::TILE_BASE_OBJ;
    addr     = {tnum, 5'd0} + {11'd0, byte_off} + base;

    hit = attr.shown && coord.in_tex;

    result = '0;
    if (hit) begin
      result.hit             = 1'b1;
      result.screen_x        = attr.screen_x;
      result.vram_offset     = addr;
      result.high_nibble     = attr.is8 ? 1'b0 : coord.tx[0];
      result.eight_bpp       = attr.is8;
      result.palette_bank    = attr.is8 ? 4'd0 : attr.palette;
      result.sprite_priority = attr.prio;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sprite_texel_address_generator.sv -----
// ----------------------------------------------------------------------------
// Sprite texel address generator
// Registers a sprite pixel request, works out its texel address in one pass
// and registers the result word.
// ----------------------------------------------------------------------------
// Timing: a word is taken into the input register, and its result is taken into
// the result register together with the result strobe.
// Throughput: one word every cycle; busy is never raised, since the whole pass is
// one short combinational path between the input register and the result register.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous reset clears the valid flags and both configuration registers.
`default_nettype none

module sprite_texel_address_generator (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire stag_pkg::stag_in_t in_item,
  output logic                 out_valid,
  output stag_pkg::stag_out_t  out_item,
  input  wire                  cfg_we,
  input  wire                  cfg_index,
  input  wire                  cfg_wdata
);

  logic                  in_valid_r;
  stag_pkg::stag_in_t    in_item_r;
  logic                  out_valid_r;
  stag_pkg::stag_out_t   out_item_r;
  stag_pkg::stag_cfg_t   cfg_r;
  stag_pkg::stag_cfg_t   cfg_nxt;
  stag_pkg::stag_attr_t  attr;
  stag_pkg::stag_coord_t coord;
  stag_pkg::stag_out_t   result;

  assign busy = 1'b0;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        stag_pkg::REG_ONE_DIM:     cfg_nxt.one_dim     = cfg_wdata;
        stag_pkg::REG_BITMAP_BASE: cfg_nxt.bitmap_base = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item_r <= in_item;
    end
    if (in_valid_r) begin
      out_item_r <= result;
    end
  end

  stag_decode u_decode (
    .item (in_item_r),
    .attr (attr)
  );

  stag_texel u_texel (
    .item  (in_item_r),
    .attr  (attr),
    .coord (coord)
  );

  stag_addr u_addr (
    .cfg    (cfg_r),
    .attr   (attr),
    .coord  (coord),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
